>>> design/fwmd_pkg.sv
`timescale 1ns / 1ps

package fwmd_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'hFF;
   localparam logic [7:0]  SYNC_SECOND = 8'h81;
   localparam logic [15:0] SYNC_WORD   = 16'h81FF;

   typedef logic [2:0] event_kind_type;

   localparam event_kind_type EV_HEADER_OK   = 3'd0;
   localparam event_kind_type EV_PAYLOAD     = 3'd1;
   localparam event_kind_type EV_FRAME_GOOD  = 3'd2;
   localparam event_kind_type EV_PAYLOAD_BAD = 3'd3;
   localparam event_kind_type EV_HEADER_BAD  = 3'd4;

   typedef enum logic [6:0] {
      PH_HUNT1 = 7'b0000001,
      PH_HUNT2 = 7'b0000010,
      PH_ID    = 7'b0000100,
      PH_COUNT = 7'b0001000,
      PH_FLAGS = 7'b0010000,
      PH_HCSUM = 7'b0100000,
      PH_DATA  = 7'b1000000
   } phase_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [15:0]    message_id;
      logic [15:0]    word_count;
      logic [15:0]    header_flags;
      logic [15:0]    word_index;
      logic [15:0]    word_value;
      logic           frame_last;
   } result_type;

endpackage

>>> design/fwmd_core.sv
`timescale 1ns / 1ps

module fwmd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           rx_byte,
   output logic                 res_valid,
   output fwmd_pkg::result_type res
);

   fwmd_pkg::phase_type phase_ff, phase_in;
   logic        high_ff, high_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] flags_ff, flags_in;
   logic [15:0] hsum_ff, hsum_in;
   logic [15:0] seen_ff, seen_in;
   logic [15:0] psum_ff, psum_in;
   logic [15:0] word;
   logic [15:0] hdr_chk;
   logic [15:0] pay_chk;

   assign word    = {rx_byte, low_ff};
   assign hdr_chk = word + hsum_ff;
   assign pay_chk = word + psum_ff;

   always_comb begin
      phase_in  = phase_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      id_in     = id_ff;
      count_in  = count_ff;
      flags_in  = flags_ff;
      hsum_in   = hsum_ff;
      seen_in   = seen_ff;
      psum_in   = psum_ff;
      res_valid = 1'b0;
      res.event_kind   = fwmd_pkg::EV_PAYLOAD;
      res.message_id   = id_ff;
      res.word_count   = count_ff;
      res.header_flags = flags_ff;
      res.word_index   = seen_ff;
      res.word_value   = word;
      res.frame_last   = 1'b0;
      case (phase_ff)
         fwmd_pkg::PH_HUNT1: begin
            if (rx_byte == fwmd_pkg::SYNC_FIRST) phase_in = fwmd_pkg::PH_HUNT2;
         end
         fwmd_pkg::PH_HUNT2: begin
            if (rx_byte == fwmd_pkg::SYNC_SECOND) begin
               phase_in = fwmd_pkg::PH_ID;
               high_in  = 1'b0;
               hsum_in  = fwmd_pkg::SYNC_WORD;
            end else begin
               phase_in = fwmd_pkg::PH_HUNT1;
            end
         end
         fwmd_pkg::PH_ID, fwmd_pkg::PH_COUNT, fwmd_pkg::PH_FLAGS: begin
            if (!high_ff) begin
               low_in  = rx_byte;
               high_in = 1'b1;
            end else begin
               high_in = 1'b0;
               hsum_in = hsum_ff + word;
               if (phase_ff == fwmd_pkg::PH_ID) begin
                  id_in    = word;
                  phase_in = fwmd_pkg::PH_COUNT;
               end else if (phase_ff == fwmd_pkg::PH_COUNT) begin
                  count_in = word;
                  phase_in = fwmd_pkg::PH_FLAGS;
               end else begin
                  flags_in = word;
                  phase_in = fwmd_pkg::PH_HCSUM;
               end
            end
         end
         fwmd_pkg::PH_HCSUM: begin
            if (!high_ff) begin
               low_in  = rx_byte;
               high_in = 1'b1;
            end else begin
               high_in        = 1'b0;
               res_valid      = 1'b1;
               res.word_index = 16'd0;
               if (hdr_chk == 16'd0) begin
                  res.event_kind = fwmd_pkg::EV_HEADER_OK;
                  phase_in       = fwmd_pkg::PH_DATA;
                  seen_in        = 16'd0;
                  psum_in        = 16'd0;
               end else begin
                  res.event_kind = fwmd_pkg::EV_HEADER_BAD;
                  res.frame_last = 1'b1;
                  phase_in       = fwmd_pkg::PH_HUNT1;
               end
            end
         end
         fwmd_pkg::PH_DATA: begin
            if (!high_ff) begin
               low_in  = rx_byte;
               high_in = 1'b1;
            end else begin
               high_in   = 1'b0;
               res_valid = 1'b1;
               if (seen_ff < count_ff) begin
                  psum_in = pay_chk;
                  seen_in = seen_ff + 16'd1;
               end else begin
                  res.event_kind = (pay_chk == 16'd0) ? fwmd_pkg::EV_FRAME_GOOD
                                                      : fwmd_pkg::EV_PAYLOAD_BAD;
                  res.frame_last = 1'b1;
                  phase_in       = fwmd_pkg::PH_HUNT1;
               end
            end
         end
         default: begin
            phase_in = fwmd_pkg::PH_HUNT1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fwmd_pkg::PH_HUNT1;
         high_ff  <= 1'b0;
         low_ff   <= 8'd0;
         id_ff    <= 16'd0;
         count_ff <= 16'd0;
         flags_ff <= 16'd0;
         hsum_ff  <= 16'd0;
         seen_ff  <= 16'd0;
         psum_ff  <= 16'd0;
      end else if (take) begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
         id_ff    <= id_in;
         count_ff <= count_in;
         flags_ff <= flags_in;
         hsum_ff  <= hsum_in;
         seen_ff  <= seen_in;
         psum_ff  <= psum_in;
      end
   end

`ifndef ASSERT_OFF
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == fwmd_pkg::PH_DATA |-> seen_ff <= count_ff)
      else $error("payload index ran past word count");

   a_bad_header_hunt: assert property (@(posedge clock) disable iff (reset)
      take && res_valid && res.event_kind == fwmd_pkg::EV_HEADER_BAD
      |=> phase_ff == fwmd_pkg::PH_HUNT1)
      else $error("bad header did not resume hunting");
`endif

endmodule

>>> design/fwmd_out_fifo.sv
`timescale 1ns / 1ps

module fwmd_out_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fwmd_pkg::result_type push_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fwmd_pkg::result_type head
);

   fwmd_pkg::result_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result buffer count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("request pushed into full result buffer");
`endif

endmodule

>>> design/framed_word_message_deframer_unit.sv
`timescale 1ns / 1ps
// Framed word message deframer.
// req channel: one received byte per request (req_valid / req_stall).
// rsp channel: one event per header checksum word and per payload word
//   (header ok, payload word, frame good, payload checksum bad, header
//   checksum bad); bytes that complete no event produce nothing.
// Pipeline: input register -> deframer logic -> 2-entry result buffer.
// Order: an accepted byte is held in the input register, its event is
//   registered into the result buffer and then shown on rsp.
// Throughput: one byte per cycle while the result buffer has room; the
//   state update per byte is a few 16-bit adds and compares.
// req_stall depends only on registered state, never combinationally on
//   rsp_stall. When the receiver stalls, up to two events wait in the
//   buffer and one byte in the input register before req_stall rises.
// Reset (synchronous, active high) empties all stages and returns the
//   deframer to hunting the first sync byte.
module framed_word_message_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [15:0] rsp_message_id,
   output logic [15:0] rsp_word_count,
   output logic [15:0] rsp_header_flags,
   output logic [15:0] rsp_word_index,
   output logic [15:0] rsp_word_value,
   output logic        rsp_frame_last
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_ready;
   logic       take;
   logic       full;
   logic       res_valid;
   fwmd_pkg::result_type res;
   fwmd_pkg::result_type head;

   assign take      = in_valid_ff && !full;
   assign in_ready  = !in_valid_ff || take;
   assign req_stall = !in_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && in_ready) in_valid_in = 1'b1;
      else if (take) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_ready) in_byte_ff <= req_rx_byte;
   end

   fwmd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   fwmd_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (take && res_valid),
      .push_data (res),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_event_kind   = head.event_kind;
   assign rsp_message_id   = head.message_id;
   assign rsp_word_count   = head.word_count;
   assign rsp_header_flags = head.header_flags;
   assign rsp_word_index   = head.word_index;
   assign rsp_word_value   = head.word_value;
   assign rsp_frame_last   = head.frame_last;

endmodule

>>> sim/framed_word_message_deframer_unit_test.sv
`timescale 1ns / 1ps

module framed_word_message_deframer_unit_test;
   import fwmd_pkg::*;

   localparam int STUCK_LIMIT = 1000;

   class deframe_scoreboard;
      phase_type    phase;
      logic         high_next;
      logic [7:0]   low_hold;
      logic [15:0]  id_q;
      logic [15:0]  count_q;
      logic [15:0]  flags_q;
      logic [16:0]  words_seen;
      logic [15:0]  payload_sum;
      result_type   pending_events[$];
      int           fail_count;

      function new();
         phase       = PH_HUNT1;
         high_next   = 1'b0;
         low_hold    = '0;
         id_q        = '0;
         count_q     = '0;
         flags_q     = '0;
         words_seen  = '0;
         payload_sum = '0;
         fail_count  = 0;
      endfunction

      function int pending();
         return pending_events.size();
      endfunction

      function bit hunting();
         return phase == PH_HUNT1;
      endfunction

      function void push_event(event_kind_type kind, logic [15:0] index,
                               logic [15:0] value, logic last);
         result_type r;
         r.event_kind   = kind;
         r.message_id   = id_q;
         r.word_count   = count_q;
         r.header_flags = flags_q;
         r.word_index   = index;
         r.word_value   = value;
         r.frame_last   = last;
         pending_events.push_back(r);
      endfunction

      // Called for each accepted request byte.
      function void note_byte(logic [7:0] b);
         logic [15:0] w;
         logic [15:0] want;
         case (phase)
            PH_HUNT1: begin
               if (b == SYNC_FIRST) phase = PH_HUNT2;
            end
            PH_HUNT2: begin
               if (b == SYNC_SECOND) begin
                  phase     = PH_ID;
                  high_next = 1'b0;
               end else begin
                  phase = PH_HUNT1;
               end
            end
            default: begin
               if (!high_next) begin
                  low_hold  = b;
                  high_next = 1'b1;
               end else begin
                  high_next = 1'b0;
                  w = {b, low_hold};
                  case (phase)
                     PH_ID: begin
                        id_q  = w;
                        phase = PH_COUNT;
                     end
                     PH_COUNT: begin
                        count_q = w;
                        phase   = PH_FLAGS;
                     end
                     PH_FLAGS: begin
                        flags_q = w;
                        phase   = PH_HCSUM;
                     end
                     PH_HCSUM: begin
                        want = -(SYNC_WORD + id_q + count_q + flags_q);
                        if (w == want) begin
                           phase       = PH_DATA;
                           words_seen  = '0;
                           payload_sum = '0;
                           push_event(EV_HEADER_OK, 16'h0, w, 1'b0);
                        end else begin
                           phase = PH_HUNT1;
                           push_event(EV_HEADER_BAD, 16'h0, w, 1'b1);
                        end
                     end
                     PH_DATA: begin
                        if (words_seen < {1'b0, count_q}) begin
                           push_event(EV_PAYLOAD, words_seen[15:0], w, 1'b0);
                           payload_sum = payload_sum + w;
                           words_seen  = words_seen + 17'd1;
                        end else begin
                           want = -payload_sum;
                           push_event((w == want) ? EV_FRAME_GOOD : EV_PAYLOAD_BAD,
                                      words_seen[15:0], w, 1'b1);
                           phase = PH_HUNT1;
                        end
                     end
                     default: phase = PH_HUNT1;
                  endcase
               end
            end
         endcase
      endfunction

      task report_mismatch(string what);
         if (fail_count < 100) $display("%0t ns mismatch: %s", $time, what);
         fail_count++;
      endtask

      task check_event(result_type got);
         result_type want;
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("event kind %0d with nothing pending",
                                      got.event_kind));
         end else begin
            want = pending_events.pop_front();
            if (got.event_kind !== want.event_kind)
               report_mismatch($sformatf("event_kind %0d, want %0d",
                                         got.event_kind, want.event_kind));
            if (got.message_id !== want.message_id)
               report_mismatch($sformatf("message_id %h, want %h",
                                         got.message_id, want.message_id));
            if (got.word_count !== want.word_count)
               report_mismatch($sformatf("word_count %h, want %h",
                                         got.word_count, want.word_count));
            if (got.header_flags !== want.header_flags)
               report_mismatch($sformatf("header_flags %h, want %h",
                                         got.header_flags, want.header_flags));
            if (got.word_index !== want.word_index)
               report_mismatch($sformatf("word_index %h, want %h",
                                         got.word_index, want.word_index));
            if (got.word_value !== want.word_value)
               report_mismatch($sformatf("word_value %h, want %h",
                                         got.word_value, want.word_value));
            if (got.frame_last !== want.frame_last)
               report_mismatch($sformatf("frame_last %b, want %b",
                                         got.frame_last, want.frame_last));
         end
      endtask
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [15:0] rsp_message_id;
   logic [15:0] rsp_word_count;
   logic [15:0] rsp_header_flags;
   logic [15:0] rsp_word_index;
   logic [15:0] rsp_word_value;
   logic        rsp_frame_last;

   deframe_scoreboard sb = new();

   bit calm           = 1'b0;
   int send_idle_mode = 0;
   int stall_mode     = 1;
   int bytes_sent     = 0;
   int stuck_cycles   = 0;

   framed_word_message_deframer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_message_id   (rsp_message_id),
      .rsp_word_count   (rsp_word_count),
      .rsp_header_flags (rsp_header_flags),
      .rsp_word_index   (rsp_word_index),
      .rsp_word_value   (rsp_word_value),
      .rsp_frame_last   (rsp_frame_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (!calm && send_idle_mode != 0 && $urandom_range(0, send_idle_mode * 3) == 0)
         gap = $urandom_range(1, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [15:0] w);
      send_byte(w[7:0]);
      send_byte(w[15:8]);
   endtask

   // Nonzero flips corrupt the header or payload checksum word.
   task automatic send_frame(input logic [15:0] id, input logic [15:0] count,
                             input logic [15:0] flags, input logic [15:0] hdr_flip,
                             input logic [15:0] sum_flip);
      logic [15:0] csum;
      logic [15:0] total;
      logic [15:0] w;
      int i;
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_word(id);
      send_word(count);
      send_word(flags);
      csum = -(SYNC_WORD + id + count + flags);
      send_word(csum ^ hdr_flip);
      if (hdr_flip == 16'h0) begin
         total = '0;
         for (i = 0; i < int'(count); i++) begin
            w = 16'($urandom);
            total = total + w;
            send_word(w);
         end
         csum = -total;
         send_word(csum ^ sum_flip);
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.event_kind   = rsp_event_kind;
         got.message_id   = rsp_message_id;
         got.word_count   = rsp_word_count;
         got.header_flags = rsp_header_flags;
         got.word_index   = rsp_word_index;
         got.word_value   = rsp_word_value;
         got.frame_last   = rsp_frame_last;
         sb.check_event(got);
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 3);
         if (!calm && stall_mode != 0 && $urandom_range(0, stall_mode * 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("FAIL framed_word_message_deframer_unit");
      $finish;
   end

   initial begin
      logic [7:0]  b;
      logic [15:0] id_w;
      logic [15:0] flags_w;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // second 0xFF is not taken as a fresh sync, so the 0x81 is ignored
      send_byte(8'h00);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_frame(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_byte(SYNC_FIRST);
      send_byte(8'h00);
      send_frame(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000);

      while (bytes_sent < 1600) begin
         send_idle_mode = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            1: begin
               send_byte(SYNC_FIRST);
               b = 8'($urandom);
               if (b == SYNC_SECOND) b = 8'h00;
               send_byte(b);
            end
            2: begin
               send_byte(SYNC_FIRST);
               send_byte(SYNC_SECOND);
               repeat ($urandom_range(1, 7)) send_byte(8'($urandom));
            end
            3: send_frame(16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom_range(1, 16'hFFFF)), 16'h0000);
            default: send_frame(16'($urandom),
                                16'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 24 : 5)),
                                16'($urandom), 16'h0000,
                                ($urandom_range(0, 3) == 0) ?
                                   16'($urandom_range(1, 16'hFFFF)) : 16'h0000);
         endcase
      end

      // run without idles or stalls; end on a maximum-count frame, first words only
      calm = 1'b1;
      while (!sb.hunting()) send_byte(8'h00);
      send_frame(16'($urandom), 16'd24, 16'($urandom), 16'h0000, 16'h0000);
      id_w    = 16'($urandom);
      flags_w = 16'($urandom);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_word(id_w);
      send_word(16'hFFFF);
      send_word(flags_w);
      send_word(-(SYNC_WORD + id_w + 16'hFFFF + flags_w));
      repeat (8) send_word(16'($urandom));

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.fail_count == 0)
         $display("PASS framed_word_message_deframer_unit");
      else
         $display("FAIL framed_word_message_deframer_unit");
      $finish;
   end

endmodule
